### hdl/tcw_pkg.sv
package tcw_pkg;

    // Geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int DATA_W = 16;
    localparam int OCOL_W = 7;
    localparam int OROW_W = 5;

    // Character and attribute codes
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;        // any request taken this cycle
        logic accept_put;    // put-character request
        logic accept_read;   // read-cell request
        logic start_clear;   // begin full-screen blank pass
        logic start_scroll;  // begin scroll copy pass
        logic scroll_step;   // one copy step of the scroll pass
        logic fill_step;     // one blank write of a fill pass
        logic emit;          // load the result registers
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic will_scroll;   // current put would move past the last row
        logic scroll_last;   // last copy step of the scroll pass
        logic fill_last;     // last cell of the fill pass
    } t_stat;

endpackage

### hdl/tcw_ctrl.sv
module tcw_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic [tcw_pkg::REQ_W-1:0]        i_req_type,
    input  tcw_pkg::t_stat                   i_stat,
    output tcw_pkg::t_cmd                    o_cmd,
    output logic                             o_busy
);

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCROLL = 4'b0100,
        S_FILL   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    unique case (tcw_pkg::t_req'(i_req_type))
                        tcw_pkg::REQ_PUT: begin
                            o_cmd.accept_put = 1'b1;
                            if (i_stat.will_scroll) begin
                                o_cmd.start_scroll = 1'b1;
                                n_state            = S_SCROLL;
                            end else begin
                                o_cmd.emit = 1'b1;
                            end
                        end
                        tcw_pkg::REQ_READ: begin
                            o_cmd.accept_read = 1'b1;
                            o_cmd.emit        = 1'b1;
                        end
                        tcw_pkg::REQ_CLEAR: begin
                            o_cmd.start_clear = 1'b1;
                            n_state           = S_FILL;
                        end
                        default: begin
                            // unused request type: report cursor only
                            o_cmd.emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_stat.scroll_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State register; reset starts the blanking pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/tcw_datapath.sv
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [tcw_pkg::ATTR_W-1:0]        i_cfg_data,
    input  logic [tcw_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]         i_cell_index,
    input  tcw_pkg::t_cmd                     i_cmd,
    output tcw_pkg::t_stat                    o_stat,
    output logic                              o_strobe,
    output logic [tcw_pkg::DATA_W-1:0]        o_cell_data,
    output logic [tcw_pkg::OCOL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]        o_cursor_row,
    output logic                              o_did_scroll
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int XW    = (CW > tcw_pkg::IDX_W) ? CW : tcw_pkg::IDX_W;
    localparam int XC    = (COL_W > tcw_pkg::OCOL_W) ? COL_W : tcw_pkg::OCOL_W;
    localparam int XR    = (ROW_W > tcw_pkg::OROW_W) ? ROW_W : tcw_pkg::OROW_W;

    localparam logic [tcw_pkg::DATA_W-1:0] RESET_CELL =
        {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};

    // Screen store
    logic [tcw_pkg::DATA_W-1:0] r_mem [CELLS];
    logic [tcw_pkg::DATA_W-1:0] r_rd_data;

    // Cursor, attribute, pass state
    logic [COL_W-1:0]           r_col;
    logic [COL_W-1:0]           n_col;
    logic [ROW_W-1:0]           r_row;
    logic [ROW_W-1:0]           n_row;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [AW-1:0]              r_cnt;
    logic [tcw_pkg::DATA_W-1:0] r_fill_cell;
    logic                       r_scroll_pend;

    // Result registers
    logic                       r_stb;
    logic [COL_W-1:0]           r_o_col;
    logic [ROW_W-1:0]           r_o_row;
    logic                       r_o_scr;
    logic                       r_o_rd;

    logic                       w_newline;
    logic [COL_W:0]             w_col_inc;
    logic                       w_wrap;
    logic                       w_last_row;
    logic [AW-1:0]              w_pos;
    logic [XW-1:0]              w_idx_ext;
    logic                       w_idx_ok;
    logic [CW-1:0]              w_src;
    logic [AW-1:0]              w_rd_addr;
    logic                       w_we;
    logic [AW-1:0]              w_wa;
    logic [tcw_pkg::DATA_W-1:0] w_wd;
    logic [XC-1:0]              w_col_x;
    logic [XR-1:0]              w_row_x;

    // Cursor advance
    assign w_newline  = (i_char_code == tcw_pkg::NEWLINE_CODE);
    assign w_col_inc  = {1'b0, r_col} + (COL_W + 1)'(1);
    assign w_wrap     = w_newline || (w_col_inc >= (COL_W + 1)'(COLUMNS));
    assign w_last_row = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.accept_put) begin
            if (w_wrap) begin
                n_col = '0;
                n_row = w_last_row ? r_row : ROW_W'(r_row + ROW_W'(1));
            end else begin
                n_col = w_col_inc[COL_W-1:0];
            end
        end
    end

    // Cell address of the cursor
    assign w_pos = AW'(AW'(r_row) * AW'(COLUMNS) + AW'(r_col));

    // Read address: request index or scroll source row
    assign w_idx_ext = XW'(i_cell_index);
    assign w_idx_ok  = (w_idx_ext < XW'(CELLS));
    assign w_src     = CW'(r_cnt) + CW'(COLUMNS);

    always_comb begin
        if (i_cmd.accept_read) begin
            w_rd_addr = w_idx_ext[AW-1:0];
        end else if (o_stat.scroll_last) begin
            w_rd_addr = '0;
        end else begin
            w_rd_addr = w_src[AW-1:0];
        end
    end

    // Write port select
    always_comb begin
        w_we = 1'b0;
        w_wa = r_cnt;
        w_wd = r_fill_cell;
        priority if (i_cmd.accept_put && !w_newline) begin
            w_we = 1'b1;
            w_wa = w_pos;
            w_wd = {r_attr, i_char_code};
        end else if (i_cmd.scroll_step && (r_cnt != '0)) begin
            w_we = 1'b1;
            w_wa = AW'(r_cnt - AW'(1));
            w_wd = r_rd_data;
        end else if (i_cmd.fill_step) begin
            w_we = 1'b1;
        end else begin
            w_we = 1'b0;
        end
    end

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Status
    assign o_stat.will_scroll = w_wrap && w_last_row;
    assign o_stat.scroll_last = (r_cnt == AW'(CELLS - COLUMNS));
    assign o_stat.fill_last   = (r_cnt == AW'(CELLS - 1));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_attr        <= tcw_pkg::RESET_ATTR;
            r_cnt         <= '0;
            r_fill_cell   <= RESET_CELL;
            r_scroll_pend <= 1'b0;
            r_stb         <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_stb <= i_cmd.emit;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_scroll_pend <= i_cmd.accept_put && o_stat.will_scroll;
            end
            if (i_cmd.start_clear || i_cmd.start_scroll) begin
                r_cnt       <= '0;
                r_fill_cell <= {r_attr, tcw_pkg::SPACE_CODE};
            end else if (i_cmd.fill_step) begin
                r_cnt <= AW'(r_cnt + AW'(1));
            end else if (i_cmd.scroll_step && !o_stat.scroll_last) begin
                r_cnt <= AW'(r_cnt + AW'(1));
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_col <= n_col;
            r_o_row <= n_row;
            r_o_scr <= i_cmd.accept ? 1'b0 : r_scroll_pend;
            r_o_rd  <= i_cmd.accept_read && w_idx_ok;
        end
    end

    assign w_col_x = XC'(r_o_col);
    assign w_row_x = XR'(r_o_row);

    assign o_strobe     = r_stb;
    assign o_cell_data  = r_o_rd ? r_rd_data : '0;
    assign o_cursor_col = w_col_x[tcw_pkg::OCOL_W-1:0];
    assign o_cursor_row = w_row_x[tcw_pkg::OROW_W-1:0];
    assign o_did_scroll = r_o_scr;

endmodule

### hdl/text_console_writer.sv
// Put without scroll, read and unused requests: result strobe in the cycle after
// the request, busy stays low, so one request per cycle is taken.
// Clear: busy while the store is blanked (one blank write per cycle), then result.
// Put that scrolls: busy during the row copy through the store's single read port
// and single write port, then during bottom-row blanking, then result.
// Reset: synchronous; after release busy is high while the store is blanked.
// Results are strobed for one cycle and cannot be stalled.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tcw_pkg::REQ_W-1:0]         i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]        i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]         i_cell_index,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [tcw_pkg::DATA_W-1:0]        o_cell_data,
    output logic [tcw_pkg::OCOL_W-1:0]        o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]        o_cursor_row,
    output logic                              o_did_scroll
);

    tcw_pkg::t_cmd  w_cmd;
    tcw_pkg::t_stat w_stat;

    // Attribute register is always writable
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_strobe     (o_strobe),
        .o_cell_data  (o_cell_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_did_scroll (o_did_scroll)
    );

    // Nonzero cell data only comes from a read request taken in the previous cycle
    a_data_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_cell_data != '0)) |->
        $past(start && !busy && (i_req_type == tcw_pkg::REQ_READ)))
        else $error("cell data reported without a read request");

    // A scroll always leaves the cursor at column zero
    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_did_scroll) |-> (o_cursor_col == '0))
        else $error("scroll result with nonzero cursor column");

    // A clear request always starts a busy pass
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == tcw_pkg::REQ_CLEAR)) |=> busy)
        else $error("clear request did not start the fill pass");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int COLS        = COLUMNS_DEF;
    localparam int ROWS_N      = ROWS_DEF;
    localparam int CELLS       = COLS * ROWS_N;
    localparam int STALL_LIMIT = 10000;
    localparam int PHASE_ITEMS = 266;
    localparam int NUM_PHASES  = 5;
    localparam int TAIL_CYCLES = 4;

    // Request code the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] cell_data;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic              scrolled;
    } console_result_t;

    // Screen and cursor tracker with the queue of expected results
    class console_scoreboard;
        logic [DATA_W-1:0] screen [CELLS];
        int                col;
        int                row;
        logic [ATTR_W-1:0] attr;
        console_result_t   expected_results [$];
        int                results_checked;
        int                errors;

        function new();
            attr            = RESET_ATTR;
            col             = 0;
            row             = 0;
            results_checked = 0;
            errors          = 0;
            blank_rows(0, ROWS_N);
        endfunction

        function void blank_rows(int first, int count);
            for (int i = first * COLS; i < (first + count) * COLS; i++) begin
                screen[i] = {attr, SPACE_CODE};
            end
        endfunction

        // Cursor to the start of the next row; scrolls past the bottom
        function logic advance_row();
            col = 0;
            row++;
            if (row >= ROWS_N) begin
                row = ROWS_N - 1;
                for (int i = 0; i + COLS < CELLS; i++) begin
                    screen[i] = screen[i + COLS];
                end
                blank_rows(ROWS_N - 1, 1);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [CHAR_W-1:0] ch,
                                   logic [IDX_W-1:0] idx);
            console_result_t r;
            r = '0;
            case (req)
                REQ_PUT: begin
                    if (ch == NEWLINE_CODE) begin
                        r.scrolled = advance_row();
                    end else begin
                        screen[row * COLS + col] = {attr, ch};
                        col++;
                        if (col >= COLS) r.scrolled = advance_row();
                    end
                end
                REQ_READ: begin
                    if (idx < CELLS) r.cell_data = screen[idx];
                end
                REQ_CLEAR: begin
                    blank_rows(0, ROWS_N);
                end
                default: ;
            endcase
            r.col = col[OCOL_W-1:0];
            r.row = row[OROW_W-1:0];
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [OCOL_W-1:0] c,
                                   logic [OROW_W-1:0] r, logic scr);
            console_result_t want;
            results_checked++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h %0d %0d %b",
                         $time, data, c, r, scr);
                return;
            end
            want = expected_results.pop_front();
            if (want.cell_data !== data) begin
                errors++;
                $display("%0t: cell_data expected %h actual %h", $time, want.cell_data, data);
            end
            if (want.col !== c) begin
                errors++;
                $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, c);
            end
            if (want.row !== r) begin
                errors++;
                $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, r);
            end
            if (want.scrolled !== scr) begin
                errors++;
                $display("%0t: did_scroll expected %b actual %b", $time, want.scrolled, scr);
            end
        endfunction
    endclass

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic [REQ_W-1:0]   i_req_type   = '0;
    logic [CHAR_W-1:0]  i_char_code  = '0;
    logic [IDX_W-1:0]   i_cell_index = '0;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [ATTR_W-1:0]  i_cfg_data   = '0;
    logic               o_strobe;
    logic [DATA_W-1:0]  o_cell_data;
    logic [OCOL_W-1:0]  o_cursor_col;
    logic [OROW_W-1:0]  o_cursor_row;
    logic               o_did_scroll;

    console_scoreboard sb;
    int                requests_issued = 0;
    int                stall_cycles    = 0;
    int                line_burst      = 0;
    logic              idling          = 1'b1;

    text_console_writer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_cell_data  (o_cell_data),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_did_scroll (o_did_scroll)
    );

    always #2 i_clk = ~i_clk;

    // Track requests, results and attribute writes at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                sb.check_result(o_cell_data, o_cursor_col, o_cursor_row, o_did_scroll);
            end
            if (start && busy === 1'b0) begin
                sb.note_request(i_req_type, i_char_code, i_cell_index);
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                sb.attr = i_cfg_data;
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (o_strobe === 1'b1 || (start && busy === 1'b0) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("[text_console_writer] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One request; start stays high after acceptance until the next call
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx);
        int gap;
        gap = idling ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        requests_issued++;
    endtask

    // Stop requesting and wait until every result is back and busy is low
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.results_checked < requests_issued || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly text with newlines and line-long bursts, reads near the cursor
    task automatic random_item();
        int            pick;
        int            here;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = IDX_W'($urandom_range(0, 2047));
        if ($urandom_range(0, 39) == 0) idling = !idling;
        if (line_burst > 0) begin
            line_burst--;
            send_request(REQ_PUT, ch, idx);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                line_burst = $urandom_range(60, 100);
                send_request(REQ_PUT, ch, idx);
            end else if (pick < 55) begin
                send_request(REQ_PUT, ch, idx);
            end else if (pick < 61) begin
                send_request(REQ_PUT, NEWLINE_CODE, idx);
            end else if (pick < 75) begin
                here = sb.row * COLS + sb.col;
                idx  = IDX_W'((here - int'($urandom_range(1, 100)) + CELLS) % CELLS);
                send_request(REQ_READ, ch, idx);
            end else if (pick < 85) begin
                send_request(REQ_READ, ch, IDX_W'($urandom_range(0, CELLS - 1)));
            end else if (pick < 89) begin
                send_request(REQ_READ, ch, IDX_W'($urandom_range(CELLS, 2047)));
            end else if (pick < 92) begin
                send_request(REQ_CLEAR, ch, idx);
            end else if (pick < 95) begin
                send_request(REQ_UNUSED, ch, idx);
            end else begin
                send_request(REQ_READ, ch, idx);
            end
        end
    endtask

    initial begin
        int items;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset contents, read bounds, unused type, char extremes, clear
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1999);
        send_request(REQ_READ, 8'h00, 11'd2000);
        send_request(REQ_READ, 8'hFF, 11'h7FF);
        send_request(REQ_UNUSED, 8'hFF, 11'h7FF);
        send_request(REQ_PUT, 8'h00, 11'd0);
        send_request(REQ_PUT, 8'hFF, 11'h7FF);
        send_request(REQ_PUT, 8'h41, 11'd5);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd1);
        send_request(REQ_READ, 8'h00, 11'd2);
        send_request(REQ_PUT, NEWLINE_CODE, 11'd0);
        send_request(REQ_PUT, 8'h55, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd80);
        send_request(REQ_UNUSED, 8'h00, 11'd0);
        send_request(REQ_CLEAR, 8'hAA, 11'h555);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd80);
        send_request(REQ_PUT, 8'h20, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd80);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1:       write_attribute(8'h00);
                    2:       write_attribute(8'hFF);
                    default: write_attribute(ATTR_W'($urandom_range(1, 254)));
                endcase
            end
            items = 0;
            while (items < PHASE_ITEMS) begin
                random_item();
                items++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("[text_console_writer] OK");
        end else begin
            $display("[text_console_writer] ERROR");
        end
        $finish;
    end

endmodule
